FILE: sv/msbs_pkg.sv
// ----------------------------------------------------------------------------
// msbs_pkg
// Shared types and constants of the multi-signature byte scanner: command
// codes, table sizes, field widths and the request and response payloads.
// ----------------------------------------------------------------------------
package msbs_pkg;

   localparam int MAX_SIGNATURES = 16;
   localparam int MAX_SIG_BYTES  = 64;

   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 7;
   localparam int IDX_W   = 4;
   localparam int POS_W   = 16;
   localparam int SLOT_W  = $clog2(MAX_SIGNATURES);
   localparam int COUNT_W = $clog2(MAX_SIGNATURES + 1);
   localparam int LANE_W  = $clog2(MAX_SIG_BYTES);

   localparam logic [POS_W-1:0] DEFAULT_SCAN_LIMIT = POS_W'(10000);

   localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SIG_BEGIN = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SIG_BYTE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SCAN_BEGIN = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SCAN_BYTE = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  sig_length;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] sig_index;
      logic [POS_W-1:0] start_offset;
      logic [LEN_W-1:0] match_length;
      logic             last;
   } rsp_type;

endpackage

FILE: sv/multi_signature_byte_scanner_top.sv
// A scan byte holds the request side while the signature rows are read, one
// memory row (one signature) per cycle unless the response channel stalls,
// the compare stage drains and the sweep ends; a scan byte past the scan limit
// or with an empty table does not stall. Other commands never raise the stall.
// Synchronous reset clears control state and the table count; reset does not
// clear the signature memory itself.
// ----------------------------------------------------------------------------
// multi_signature_byte_scanner_top
// Loads up to 16 byte signatures into a row-wide memory and reports each
// signature that ends at the current scan byte, in signature order.
// ----------------------------------------------------------------------------
module multi_signature_byte_scanner_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  msbs_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output msbs_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);
   import msbs_pkg::*;

   // signature memory: one row per signature, byte lanes; a signature of
   // length L keeps byte j in lane L-1-j so lane a lines up with window age a
   logic [BYTE_W-1:0] sig_mem [MAX_SIGNATURES][MAX_SIG_BYTES];
   logic [BYTE_W-1:0] rd_row_ff [MAX_SIG_BYTES];

   logic [LEN_W-1:0]   sig_len_ff [MAX_SIGNATURES];
   logic [BYTE_W-1:0]  win_ff [MAX_SIG_BYTES];

   logic [COUNT_W-1:0] count_ff;
   logic [LEN_W-1:0]   lp_ff;
   logic               open_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   limit_ff;
   logic               busy_ff;
   logic [COUNT_W-1:0] next_s_ff;
   logic               cmp_vld_ff;
   logic [SLOT_W-1:0]  cmp_slot_ff;
   logic               pend_vld_ff;
   rsp_type            pend_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               req_fire;
   logic               sig_begin_ok;
   logic               sig_byte_ok;
   logic               scan_ok;
   logic [SLOT_W-1:0]  cur_row;
   logic [LEN_W-1:0]   cur_len;
   logic [LEN_W-1:0]   lane_full;
   logic               wr_en;
   logic               wr_all;
   logic [SLOT_W-1:0]  wr_row;
   logic [LANE_W-1:0]  wr_lane;
   logic [BYTE_W-1:0]  wr_byte;

   logic [LEN_W-1:0]   cmp_len;
   logic               lanes_ok;
   logic               cmp_match;
   logic               out_free;
   logic               issue;
   logic               cmp_adv;
   logic               finish;
   logic               push_mid;
   logic               push_last;
   rsp_type            new_hit;
   rsp_type            out_hit;

   assign req_stall   = busy_ff;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign req_fire = req_valid && !busy_ff;

   // load side
   assign cur_row   = SLOT_W'(count_ff - COUNT_W'(1));
   assign cur_len   = sig_len_ff[cur_row];
   assign lane_full = cur_len - LEN_W'(1) - lp_ff;

   assign sig_begin_ok = req_fire && req_payload.command == CMD_SIG_BEGIN
                         && count_ff < COUNT_W'(MAX_SIGNATURES)
                         && req_payload.sig_length != '0
                         && req_payload.sig_length <= LEN_W'(MAX_SIG_BYTES);
   assign sig_byte_ok  = req_fire && req_payload.command == CMD_SIG_BYTE
                         && open_ff && count_ff != '0 && lp_ff < cur_len;
   assign scan_ok      = req_fire && req_payload.command == CMD_SCAN_BYTE
                         && pos_ff < limit_ff;

   always_comb begin
      wr_en   = sig_begin_ok || sig_byte_ok;
      wr_all  = sig_begin_ok;
      wr_row  = sig_begin_ok ? count_ff[SLOT_W-1:0] : cur_row;
      wr_lane = lane_full[LANE_W-1:0];
      wr_byte = sig_begin_ok ? '0 : req_payload.data_byte;
   end

   // compare stage
   assign cmp_len = sig_len_ff[cmp_slot_ff];

   always_comb begin
      lanes_ok = 1'b1;
      for (int a = 0; a < MAX_SIG_BYTES; a++) begin
         if (LEN_W'(a) < cmp_len && win_ff[a] != rd_row_ff[a]) begin
            lanes_ok = 1'b0;
         end
      end
   end

   assign cmp_match = cmp_vld_ff && lanes_ok && pos_ff >= POS_W'(cmp_len);

   always_comb begin
      new_hit.sig_index    = IDX_W'(cmp_slot_ff);
      new_hit.start_offset = pos_ff - POS_W'(cmp_len);
      new_hit.match_length = cmp_len;
      new_hit.last         = 1'b0;
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cmp_adv   = cmp_vld_ff && (!cmp_match || !pend_vld_ff || out_free);
   assign issue     = busy_ff && next_s_ff < count_ff && (!cmp_vld_ff || cmp_adv);
   assign finish    = busy_ff && next_s_ff >= count_ff && !cmp_vld_ff
                      && (!pend_vld_ff || out_free);
   // a hit waits in pend until the next hit or the end of the row sweep
   // decides its last flag
   assign push_mid  = cmp_adv && cmp_match && pend_vld_ff;
   assign push_last = finish && pend_vld_ff;

   always_comb begin
      out_hit      = pend_ff;
      out_hit.last = push_last;
   end

   // memory write and registered row read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int b = 0; b < MAX_SIG_BYTES; b++) begin
            if (wr_all || wr_lane == LANE_W'(b)) begin
               sig_mem[wr_row][b] <= wr_byte;
            end
         end
      end
      if (issue) begin
         for (int b = 0; b < MAX_SIG_BYTES; b++) begin
            rd_row_ff[b] <= sig_mem[next_s_ff[SLOT_W-1:0]][b];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (sig_begin_ok) begin
         sig_len_ff[count_ff[SLOT_W-1:0]] <= req_payload.sig_length;
      end
      if (scan_ok) begin
         win_ff[0] <= req_payload.data_byte;
         for (int a = 1; a < MAX_SIG_BYTES; a++) begin
            win_ff[a] <= win_ff[a-1];
         end
      end
      if (issue) begin
         cmp_slot_ff <= next_s_ff[SLOT_W-1:0];
      end
      if (cmp_adv && cmp_match) begin
         pend_ff <= new_hit;
      end
      if (push_mid || push_last) begin
         rsp_data_ff <= out_hit;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lp_ff        <= '0;
         open_ff      <= 1'b0;
         pos_ff       <= '0;
         limit_ff     <= DEFAULT_SCAN_LIMIT;
         busy_ff      <= 1'b0;
         next_s_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_data;
         end

         if (req_fire) begin
            unique case (req_payload.command)
               CMD_CLEAR: begin
                  count_ff <= '0;
                  lp_ff    <= '0;
                  open_ff  <= 1'b0;
               end
               CMD_SIG_BEGIN: begin
                  if (sig_begin_ok) begin
                     count_ff <= count_ff + COUNT_W'(1);
                     lp_ff    <= '0;
                     open_ff  <= 1'b1;
                  end else begin
                     open_ff <= 1'b0;
                  end
               end
               CMD_SIG_BYTE: begin
                  if (sig_byte_ok) begin
                     lp_ff <= lp_ff + LEN_W'(1);
                  end
               end
               CMD_SCAN_BEGIN: begin
                  pos_ff <= '0;
               end
               CMD_SCAN_BYTE: begin
                  if (scan_ok) begin
                     pos_ff    <= pos_ff + POS_W'(1);
                     next_s_ff <= '0;
                     busy_ff   <= count_ff != '0;
                  end
               end
               default: begin
               end
            endcase
         end

         if (issue) begin
            next_s_ff  <= next_s_ff + COUNT_W'(1);
            cmp_vld_ff <= 1'b1;
         end else if (cmp_adv) begin
            cmp_vld_ff <= 1'b0;
         end

         if (cmp_adv && cmp_match) begin
            pend_vld_ff <= 1'b1;
         end else if (push_last) begin
            pend_vld_ff <= 1'b0;
         end

         if (finish) begin
            busy_ff <= 1'b0;
         end

         if (push_mid || push_last) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
